@@ hw/rtl/tlw_pkg.sv @@
`default_nettype none

package tlw_pkg;

  // Widths of the output text index and of the line length counter.
  localparam int IndexBits = 24;
  localparam int LenBits   = 14;
  localparam int ModeBits  = 3;
  localparam int ByteBits  = 8;
  localparam int WideBits  = (IndexBits > LenBits) ? IndexBits : LenBits;

  // Column limit and counter ceilings.
  localparam logic [LenBits-1:0]   MaxColumn = LenBits'(10000);
  localparam logic [LenBits-1:0]   LenMax    = '1;
  localparam logic [IndexBits-1:0] IndexMax  = '1;

  // Result queue depth.
  localparam int FifoDepth = 4;
  localparam int PtrBits   = $clog2(FifoDepth);
  localparam int CountBits = $clog2(FifoDepth + 1);

  // Register indexes on the configuration port.
  localparam logic RegWrapColumn = 1'b0;
  localparam logic RegWrapMode   = 1'b1;

  // Wrap mode codes.
  localparam logic [ModeBits-1:0] ModeNone  = 3'd0;
  localparam logic [ModeBits-1:0] ModeWords = 3'd1;
  localparam logic [ModeBits-1:0] ModeOld   = 3'd2;
  localparam logic [ModeBits-1:0] ModeFill  = 3'd3;
  localparam logic [ModeBits-1:0] ModeSolid = 3'd4;

  // Characters of interest.
  localparam logic [ByteBits-1:0] CharNewline = 8'h0A;
  localparam logic [ByteBits-1:0] CharSpace   = 8'h20;
  localparam logic [ByteBits-1:0] CharPeriod  = 8'h2E;
  localparam logic [ByteBits-1:0] CharComma   = 8'h2C;
  localparam logic [ByteBits-1:0] CharSlash   = 8'h2F;

  // One write into the output text.
  typedef struct packed {
    logic [IndexBits-1:0] index;
    logic [ByteBits-1:0]  data;
    logic                 patch;
    logic                 last;
  } res_t;

  function automatic logic is_break(input logic [ByteBits-1:0] b);
    is_break = (b == CharSpace) || (b == CharPeriod) || (b == CharComma) ||
               (b == CharSlash);
  endfunction

  function automatic logic [IndexBits-1:0] index_inc(input logic [IndexBits-1:0] i);
    index_inc = (i == IndexMax) ? i : i + IndexBits'(1);
  endfunction

  function automatic logic [LenBits-1:0] len_inc(input logic [LenBits-1:0] l);
    len_inc = (l == LenMax) ? l : l + LenBits'(1);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/text_line_wrapper.sv @@
// Text line wrapper: greedy word wrap, solid blocks or pass-through on bytes.
// Input channel (in_valid/in_ready) carries one character per transfer,
// with first_of_text clearing the line state before that character.
// Output channel (out_valid/out_ready) carries writes into the output text
// as (out_index, out_byte) pairs; is_patch marks a rewrite of an earlier
// break to newline, last_of_run marks the final write caused by one byte.
// Configuration: cfg_write with cfg_index 0 sets wrap_column, index 1 sets
// wrap_mode; writes take effect at the next edge. They are to be made while
// idle; the block leaves this to the user. A byte's writes enter the
// result queue at its transfer and leave it in order; a second write (patch
// or inserted newline) follows the first one. Throughput: one byte per cycle
// while each byte gives one write and out_ready stays high; the output port
// moves one write per cycle while out_ready is high. The line state updates
// in the cycle of the transfer. Results sit in a four-entry queue; in_ready
// is high while at least two entries are free, so a stalled receiver backs
// up the input after a few bytes and nothing is lost. Reset clears the line
// state and the queue and sets wrap_column to 1 and wrap_mode to 0.
`default_nettype none

module text_line_wrapper (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [tlw_pkg::ByteBits-1:0]     in_byte,
  input  wire                              first_of_text,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [tlw_pkg::IndexBits-1:0]    out_index,
  output logic [tlw_pkg::ByteBits-1:0]     out_byte,
  output logic                             is_patch,
  output logic                             last_of_run,
  input  wire                              cfg_write,
  input  wire                              cfg_index,
  input  wire  [tlw_pkg::LenBits-1:0]      cfg_data
);
  import tlw_pkg::*;

  logic [LenBits-1:0]   wrap_column;
  logic [ModeBits-1:0]  wrap_mode;
  logic [LenBits-1:0]   line_length, line_length_next;
  logic [IndexBits-1:0] break_index, break_index_next;
  logic                 break_valid, break_valid_next;
  logic [IndexBits-1:0] write_index, write_index_next;

  res_t                 fifo_mem [FifoDepth];
  logic [PtrBits-1:0]   wr_ptr, rd_ptr;
  logic [CountBits-1:0] count;

  logic                 in_xfer, out_xfer;
  logic                 push0, push1;
  res_t                 r0, r1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_column <= LenBits'(1);
      wrap_mode   <= ModeNone;
    end else if (cfg_write) begin
      if (cfg_index == RegWrapColumn) begin
        wrap_column <= cfg_data;
      end else begin
        wrap_mode <= cfg_data[ModeBits-1:0];
      end
    end
  end

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // Per-byte wrap decision and next line state.
  always_comb begin
    logic [LenBits-1:0]   col;
    logic [ByteBits-1:0]  b;
    logic [IndexBits-1:0] wi, wi1, after;
    logic [WideBits-1:0]  after_wide;

    col = wrap_column;
    if (col == '0) begin
      col = LenBits'(1);
    end else if (col > MaxColumn) begin
      col = MaxColumn;
    end

    // A new text starts from cleared counters.
    if (first_of_text) begin
      line_length_next = '0;
      break_index_next = '0;
      break_valid_next = 1'b0;
      wi               = '0;
    end else begin
      line_length_next = line_length;
      break_index_next = break_index;
      break_valid_next = break_valid;
      wi               = write_index;
    end

    b                = in_byte;
    wi1              = index_inc(wi);
    after            = '0;
    after_wide       = '0;
    write_index_next = wi1;
    push0            = 1'b1;
    push1            = 1'b0;
    r0               = '{index: wi, data: b, patch: 1'b0, last: 1'b1};
    r1               = '{index: wi1, data: CharNewline, patch: 1'b0, last: 1'b1};

    case (wrap_mode)
      ModeWords, ModeFill: begin
        if ((wrap_mode == ModeFill) && (b == CharNewline)) begin
          b = CharSpace;
        end
        r0.data = b;
        if (b == CharNewline) begin
          line_length_next = '0;
          break_valid_next = 1'b0;
        end else begin
          if (is_break(b)) begin
            break_index_next = wi;
            break_valid_next = 1'b1;
          end
          line_length_next = len_inc(line_length_next);
        end
        // Line too long: turn the last break into a newline.
        if ((line_length_next > col) && break_valid_next) begin
          push1      = 1'b1;
          r1.index   = break_index_next;
          r1.patch   = 1'b1;
          after      = wi - break_index_next;
          after_wide = WideBits'(after);
          if (after_wide > WideBits'(LenMax)) begin
            line_length_next = LenMax;
          end else begin
            line_length_next = LenBits'(after_wide);
          end
          break_valid_next = 1'b0;
        end
      end
      ModeSolid: begin
        if (b == CharNewline) begin
          // Newlines are dropped in solid blocks.
          push0            = 1'b0;
          write_index_next = wi;
        end else begin
          line_length_next = len_inc(line_length_next);
          if (line_length_next >= col) begin
            push1            = 1'b1;
            write_index_next = index_inc(wi1);
            line_length_next = '0;
          end
        end
      end
      default: begin
      end
    endcase

    r0.last = !push1;
  end

  // Line state.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= '0;
      break_index <= '0;
      break_valid <= 1'b0;
      write_index <= '0;
    end else if (in_xfer) begin
      line_length <= line_length_next;
      break_index <= break_index_next;
      break_valid <= break_valid_next;
      write_index <= write_index_next;
    end
  end

  // Result queue storage.
  always_ff @(posedge clk) begin
    if (in_xfer && push0) begin
      fifo_mem[wr_ptr] <= r0;
    end
    if (in_xfer && push1) begin
      fifo_mem[wr_ptr + PtrBits'(1)] <= r1;
    end
  end

  // Result queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrBits'(in_xfer && push0) + PtrBits'(in_xfer && push1);
      rd_ptr <= rd_ptr + PtrBits'(out_xfer);
      count  <= count + CountBits'(in_xfer && push0) + CountBits'(in_xfer && push1)
                - CountBits'(out_xfer);
    end
  end

  assign in_ready    = (count <= CountBits'(FifoDepth - 2));
  assign out_valid   = (count != '0);
  assign out_index   = fifo_mem[rd_ptr].index;
  assign out_byte    = fifo_mem[rd_ptr].data;
  assign is_patch    = fifo_mem[rd_ptr].patch;
  assign last_of_run = fifo_mem[rd_ptr].last;

endmodule

`default_nettype wire

@@ hw/rtl/tlw_checker.sv @@
`default_nettype none

module tlw_checker (
  input wire                             clk,
  input wire                             rst,
  input wire                             out_valid,
  input wire                             out_ready,
  input wire [tlw_pkg::IndexBits-1:0]    out_index,
  input wire [tlw_pkg::ByteBits-1:0]     out_byte,
  input wire                             is_patch,
  input wire                             last_of_run
);
  import tlw_pkg::*;

  // Reset empties the result queue.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // A patch always rewrites a position to newline.
  a_patch_newline: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_patch) |-> (out_byte == CharNewline))
    else $error("patch carries a byte other than newline");

  // A patch is always the final write of its byte.
  a_patch_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_patch) |-> last_of_run)
    else $error("patch not marked as last of run");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_index) && $stable(out_byte) && $stable(is_patch)
       && $stable(last_of_run)))
    else $error("stalled result changed");

endmodule

bind text_line_wrapper tlw_checker u_tlw_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_index   (out_index),
  .out_byte    (out_byte),
  .is_patch    (is_patch),
  .last_of_run (last_of_run)
);

`default_nettype wire
